>>> sv/edpt_pkg.sv
`timescale 1ns / 1ps
package edpt_pkg;

	localparam int MAX_POINTS = 64;
	localparam int MAX_DIMS   = 4;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int COORD_W    = 16;
	localparam int RAD_W      = 16;
	localparam int DIMS_W     = 3;
	localparam int DIFF_W     = COORD_W + 1;
	localparam int SQ_W       = 2 * COORD_W;
	localparam int SUM_W      = SQ_W + $clog2(MAX_DIMS);
	localparam int R2_W       = 2 * RAD_W;
	localparam logic [DIMS_W-1:0] DIMS_RESET = DIMS_W'(MAX_DIMS);

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] coord_a;
		logic signed [COORD_W-1:0] coord_b;
		logic signed [COORD_W-1:0] coord_c;
		logic signed [COORD_W-1:0] coord_d;
		logic [RAD_W-1:0]          radius;
		logic                      final_point;
	} edpt_in_t;

	typedef struct packed {
		logic [5:0] point_index;
		logic       retained;
		logic       capacity_exceeded;
		logic       end_of_set;
	} edpt_out_t;

	typedef struct packed {
		coord_t [MAX_DIMS-1:0] coords;
		logic [RAD_W-1:0]      radius;
	} edpt_entry_t;

	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] tag;
	} edpt_req_t;

	typedef struct packed {
		logic             valid;
		logic             hit;
		logic [IDX_W-1:0] tag;
	} edpt_hit_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REF,
		ST_REF_CAP,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} edpt_state_t;

	function automatic logic [MAX_DIMS-1:0] lane_mask(input logic [DIMS_W-1:0] dims);
		logic [MAX_DIMS-1:0] m;
		m = '0;
		for (int k = 0; k < MAX_DIMS; k++) begin
			if (k == 0 || DIMS_W'(k) < dims) begin
				m[k] = 1'b1;
			end
		end
		return m;
	endfunction

endpackage

>>> sv/edpt_store.sv
`timescale 1ns / 1ps
module edpt_store (
	input  logic                                clk,
	input  logic                                we,
	input  logic [edpt_pkg::IDX_W-1:0]          waddr,
	input  edpt_pkg::edpt_entry_t               wdata,
	input  logic                                re,
	input  logic [edpt_pkg::IDX_W-1:0]          raddr,
	output edpt_pkg::edpt_entry_t               rdata
);
	import edpt_pkg::*;

	edpt_entry_t mem_q [MAX_POINTS];
	edpt_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sv/edpt_dist.sv
`timescale 1ns / 1ps
module edpt_dist (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              ref_load,
	input  edpt_pkg::edpt_entry_t             rdata,
	input  edpt_pkg::edpt_req_t               req,
	input  logic [edpt_pkg::DIMS_W-1:0]       dims,
	output edpt_pkg::edpt_hit_t               res,
	output logic                              pipe_busy
);
	import edpt_pkg::*;

	edpt_entry_t ref_q;
	logic [R2_W-1:0] r2_q;

	logic [MAX_DIMS-1:0] mask;
	logic signed [DIFF_W-1:0] diff [MAX_DIMS];
	logic signed [2*DIFF_W-1:0] prod [MAX_DIMS];
	logic [SUM_W-1:0] sum;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic [IDX_W-1:0] tag_s1, tag_s2, tag_s3, tag_s4;
	logic signed [DIFF_W-1:0] diff_s1 [MAX_DIMS];
	logic [SQ_W-1:0] sq_s2 [MAX_DIMS];
	logic [SUM_W-1:0] sum_s3;
	logic hit_s4;

	assign mask = lane_mask(dims);

	always_ff @(posedge clk) begin
		if (ref_load) begin
			ref_q <= rdata;
		end
		r2_q <= R2_W'(ref_q.radius) * R2_W'(ref_q.radius);
	end

	always_comb begin
		for (int k = 0; k < MAX_DIMS; k++) begin
			diff[k] = mask[k] ? (DIFF_W'(rdata.coords[k]) - DIFF_W'(ref_q.coords[k]))
				: '0;
			prod[k] = diff_s1[k] * diff_s1[k];
		end
		sum = '0;
		for (int k = 0; k < MAX_DIMS; k++) begin
			sum = sum + SUM_W'(sq_s2[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= req.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1 <= req.tag;
		tag_s2 <= tag_s1;
		tag_s3 <= tag_s2;
		tag_s4 <= tag_s3;
		for (int k = 0; k < MAX_DIMS; k++) begin
			diff_s1[k] <= diff[k];
			sq_s2[k]   <= prod[k][SQ_W-1:0];
		end
		sum_s3 <= sum;
		hit_s4 <= sum_s3 < SUM_W'(r2_q);
	end

	assign res.valid = valid_s4;
	assign res.hit   = hit_s4;
	assign res.tag   = tag_s4;
	assign pipe_busy = valid_s1 | valid_s2 | valid_s3 | valid_s4;

endmodule

>>> sv/edpt_ctrl.sv
`timescale 1ns / 1ps
module edpt_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  edpt_pkg::edpt_in_t                item,
	input  logic                              cfg_we,
	input  logic [edpt_pkg::DIMS_W-1:0]       cfg_data,
	output logic                              mem_we,
	output logic [edpt_pkg::IDX_W-1:0]        mem_waddr,
	output edpt_pkg::edpt_entry_t             mem_wdata,
	output logic                              mem_re,
	output logic [edpt_pkg::IDX_W-1:0]        mem_raddr,
	output logic                              ref_load,
	output edpt_pkg::edpt_req_t               req,
	output logic [edpt_pkg::DIMS_W-1:0]       dims,
	input  edpt_pkg::edpt_hit_t               res,
	input  logic                              pipe_busy,
	output logic                              result_valid,
	output edpt_pkg::edpt_out_t               result
);
	import edpt_pkg::*;

	edpt_state_t state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic ovf_q, ovf_d;
	logic [MAX_POINTS-1:0] keep_q;
	logic [DIMS_W-1:0] dims_q;
	logic [CNT_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
	logic rd_valid_q, rd_valid_d;
	logic [IDX_W-1:0] rd_tag_q;
	logic accept, has_room, set_end;
	logic [CNT_W-1:0] n_final;

	assign accept   = start && (state_q == ST_IDLE);
	assign has_room = count_q < CNT_W'(MAX_POINTS);
	assign n_final  = has_room ? count_q + CNT_W'(1) : count_q;
	assign set_end  = (state_q == ST_EMIT) && (k_q + CNT_W'(1) == count_q);

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		ovf_d      = ovf_q;
		i_d        = i_q;
		j_d        = j_q;
		k_d        = k_q;
		rd_valid_d = 1'b0;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		mem_raddr  = i_q[IDX_W-1:0];
		ref_load   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (has_room) begin
						mem_we  = 1'b1;
						count_d = count_q + CNT_W'(1);
					end else begin
						ovf_d = 1'b1;
					end
					if (item.final_point) begin
						i_d = '0;
						k_d = '0;
						state_d = (n_final >= CNT_W'(2)) ? ST_REF : ST_EMIT;
					end
				end
			end
			ST_REF: begin
				if (i_q + CNT_W'(1) >= count_q) begin
					k_d = '0;
					state_d = ST_EMIT;
				end else if (!keep_q[i_q[IDX_W-1:0]]) begin
					i_d = i_q + CNT_W'(1);
				end else begin
					mem_re  = 1'b1;
					state_d = ST_REF_CAP;
				end
			end
			ST_REF_CAP: begin
				ref_load = 1'b1;
				j_d = i_q + CNT_W'(1);
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				mem_re     = 1'b1;
				mem_raddr  = j_q[IDX_W-1:0];
				rd_valid_d = 1'b1;
				if (j_q + CNT_W'(1) >= count_q) begin
					state_d = ST_DRAIN;
				end else begin
					j_d = j_q + CNT_W'(1);
				end
			end
			ST_DRAIN: begin
				if (!rd_valid_q && !pipe_busy) begin
					i_d = i_q + CNT_W'(1);
					state_d = ST_REF;
				end
			end
			ST_EMIT: begin
				if (set_end) begin
					count_d = '0;
					ovf_d   = 1'b0;
					state_d = ST_IDLE;
				end else begin
					k_d = k_q + CNT_W'(1);
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			ovf_q      <= 1'b0;
			keep_q     <= '1;
			dims_q     <= DIMS_RESET;
			i_q        <= '0;
			j_q        <= '0;
			k_q        <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			ovf_q      <= ovf_d;
			i_q        <= i_d;
			j_q        <= j_d;
			k_q        <= k_d;
			rd_valid_q <= rd_valid_d;
			if (cfg_we) begin
				dims_q <= cfg_data;
			end
			if (set_end) begin
				keep_q <= '1;
			end else if (res.valid && res.hit) begin
				keep_q[res.tag] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_tag_q <= j_q[IDX_W-1:0];
	end

	assign busy      = state_q != ST_IDLE;
	assign mem_waddr = count_q[IDX_W-1:0];
	assign mem_wdata.coords[0] = item.coord_a;
	assign mem_wdata.coords[1] = item.coord_b;
	assign mem_wdata.coords[2] = item.coord_c;
	assign mem_wdata.coords[3] = item.coord_d;
	assign mem_wdata.radius    = item.radius;
	assign req.valid = rd_valid_q;
	assign req.tag   = rd_tag_q;
	assign dims      = dims_q;

	assign result_valid             = state_q == ST_EMIT;
	assign result.point_index       = 6'(k_q[IDX_W-1:0]);
	assign result.retained          = keep_q[k_q[IDX_W-1:0]];
	assign result.capacity_exceeded = ovf_q;
	assign result.end_of_set        = set_end;

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_POINTS))
		else $error("point count above capacity");

	a_clear_after_set: assert property (@(posedge clk) disable iff (!arst_n)
		set_end |=> (count_q == '0) && (&keep_q) && !ovf_q)
		else $error("set state not cleared after last beat");

	a_hit_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
		else $error("distance result outside scan");

	a_hit_later: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (CNT_W'(res.tag) > i_q) && (CNT_W'(res.tag) < count_q))
		else $error("knockout target out of range");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!rd_valid_q && !pipe_busy))
		else $error("pipeline active while idle");

endmodule

>>> sv/epsilon_distinct_point_thinning.sv
`timescale 1ns / 1ps
// channel   signals                         dir  beat
// item      start, busy, item               in   start && !busy
// config    cfg_we, cfg_data                in   cfg_we
// result    result_valid, result            out  result_valid, one cycle
//
// Points are stored while idle up to capacity; a final one starts the compare pass:
// per kept point i, a reference fetch (ST_REF, ST_REF_CAP), a scan of the later
// points (one memory read per pair) and a pipeline drain; a knocked-out or last
// point is skipped; then n result beats. One read port: one pair per cycle.
// Reset clears counts and keep flags at once; no clearing pass.
// busy stays high from the final point until the last result beat; no result stall.
module epsilon_distinct_point_thinning (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  edpt_pkg::edpt_in_t          item,
	input  logic                        cfg_we,
	input  logic [edpt_pkg::DIMS_W-1:0] cfg_data,
	output logic                        result_valid,
	output edpt_pkg::edpt_out_t         result
);
	import edpt_pkg::*;

	logic mem_we, mem_re, ref_load, pipe_busy;
	logic [IDX_W-1:0] mem_waddr, mem_raddr;
	edpt_entry_t mem_wdata, mem_rdata;
	edpt_req_t req;
	edpt_hit_t res;
	logic [DIMS_W-1:0] dims;

	edpt_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_re       (mem_re),
		.mem_raddr    (mem_raddr),
		.ref_load     (ref_load),
		.req          (req),
		.dims         (dims),
		.res          (res),
		.pipe_busy    (pipe_busy),
		.result_valid (result_valid),
		.result       (result)
	);

	edpt_store u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	edpt_dist u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.ref_load  (ref_load),
		.rdata     (mem_rdata),
		.req       (req),
		.dims      (dims),
		.res       (res),
		.pipe_busy (pipe_busy)
	);

endmodule

>>> dv/edpt_checker.sv
`timescale 1ns / 1ps
module edpt_checker
	import edpt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  edpt_in_t          item,
	input  logic              cfg_we,
	input  logic [DIMS_W-1:0] cfg_data,
	input  logic              result_valid,
	input  edpt_out_t         result,
	output int                errors,
	output int                expected_left
);

	coord_t            pts [MAX_POINTS][MAX_DIMS];
	logic [RAD_W-1:0]  radii [MAX_POINTS];
	int unsigned       stored;
	bit                overflow;
	logic [DIMS_W-1:0] dims_reg;
	edpt_out_t         flags_due[$];

	initial begin
		errors = 0;
		expected_left = 0;
	end

	task automatic report_mismatch(input string what);
		$display("%0t: mismatch: %s", $realtime, what);
		errors++;
	endtask

	function automatic longint unsigned gap_sq(input int a, input int b, input int lanes);
		longint unsigned sum;
		longint          diff;
		sum = 0;
		for (int k = 0; k < lanes; k++) begin
			diff = longint'(pts[a][k]) - longint'(pts[b][k]);
			sum += unsigned'(diff * diff);
		end
		return sum;
	endfunction

	task automatic close_set();
		bit                kept [MAX_POINTS];
		longint unsigned   reach;
		int                lanes;
		edpt_out_t         beat;
		lanes = (dims_reg == 0) ? 1 : (dims_reg > MAX_DIMS) ? MAX_DIMS : int'(dims_reg);
		for (int i = 0; i < MAX_POINTS; i++) kept[i] = 1'b1;
		for (int i = 0; i + 1 < int'(stored); i++) begin
			if (kept[i]) begin
				reach = 64'(radii[i]) * 64'(radii[i]);
				for (int j = i + 1; j < int'(stored); j++) begin
					if (gap_sq(i, j, lanes) < reach) kept[j] = 1'b0;
				end
			end
		end
		for (int i = 0; i < int'(stored); i++) begin
			beat.point_index       = 6'(i);
			beat.retained          = kept[i];
			beat.capacity_exceeded = overflow;
			beat.end_of_set        = (i + 1 == int'(stored));
			flags_due.push_back(beat);
		end
		stored   = 0;
		overflow = 1'b0;
	endtask

	task automatic absorb_point(input edpt_in_t p);
		if (stored < MAX_POINTS) begin
			pts[stored][0] = p.coord_a;
			pts[stored][1] = p.coord_b;
			pts[stored][2] = p.coord_c;
			pts[stored][3] = p.coord_d;
			radii[stored]  = p.radius;
			stored++;
		end else begin
			overflow = 1'b1;
		end
		if (p.final_point) close_set();
	endtask

	task automatic check_beat(input edpt_out_t got);
		edpt_out_t want;
		if (flags_due.size() == 0) begin
			report_mismatch($sformatf("unexpected result beat index %0d", got.point_index));
			return;
		end
		want = flags_due.pop_front();
		if (got.point_index !== want.point_index)
			report_mismatch($sformatf("point_index got %0d want %0d",
				got.point_index, want.point_index));
		if (got.retained !== want.retained)
			report_mismatch($sformatf("retained idx %0d got %b want %b",
				want.point_index, got.retained, want.retained));
		if (got.capacity_exceeded !== want.capacity_exceeded)
			report_mismatch($sformatf("capacity_exceeded idx %0d got %b want %b",
				want.point_index, got.capacity_exceeded, want.capacity_exceeded));
		if (got.end_of_set !== want.end_of_set)
			report_mismatch($sformatf("end_of_set idx %0d got %b want %b",
				want.point_index, got.end_of_set, want.end_of_set));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored   = 0;
			overflow = 1'b0;
			dims_reg = DIMS_RESET;
			flags_due.delete();
		end else begin
			if (result_valid !== 1'b0) check_beat(result);
			if (cfg_we) dims_reg = cfg_data;
			if (start && !busy) absorb_point(item);
		end
		expected_left = flags_due.size();
	end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import edpt_pkg::*;

	localparam int LIMIT  = 400000;
	localparam int SETTLE = 12;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	edpt_in_t          item;
	logic              cfg_we;
	logic [DIMS_W-1:0] cfg_data;
	logic              result_valid;
	edpt_out_t         result;
	int                errors;
	int                expected_left;
	int                cycles = 0;
	int                burst_left = 0;
	int                points_sent = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	epsilon_distinct_point_thinning i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result       (result)
	);

	edpt_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.item          (item),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.result_valid  (result_valid),
		.result        (result),
		.errors        (errors),
		.expected_left (expected_left)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic edpt_in_t mk_point(input int a, input int b, input int c, input int d,
			input int r, input bit fin);
		edpt_in_t p;
		p.coord_a     = coord_t'(a);
		p.coord_b     = coord_t'(b);
		p.coord_c     = coord_t'(c);
		p.coord_d     = coord_t'(d);
		p.radius      = RAD_W'(r);
		p.final_point = fin;
		return p;
	endfunction

	// mode 0: full range, mode 1: loose cluster, mode 2: tight cluster near the radius
	function automatic edpt_in_t rand_point(input int mode, input int ctr[4], input bit fin);
		int c[4];
		int r;
		for (int k = 0; k < 4; k++) begin
			case (mode)
				0: c[k] = $urandom;
				1: c[k] = ctr[k] + int'($urandom_range(0, 4000)) - 2000;
				default: c[k] = ctr[k] + int'($urandom_range(0, 16)) - 8;
			endcase
		end
		case (mode)
			0: r = $urandom_range(0, 65535);
			1: r = $urandom_range(0, 5000);
			default: r = $urandom_range(0, 16);
		endcase
		if ($urandom_range(0, 9) == 0) r = 0;
		return mk_point(c[0], c[1], c[2], c[3], r, fin);
	endfunction

	task automatic send_point(input edpt_in_t p);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if ($urandom_range(0, 3) != 0) begin
				repeat ($urandom_range(1, 6)) begin
					@(negedge clk);
					start = 1'b0;
				end
			end
		end
		burst_left--;
		@(negedge clk);
		start = 1'b1;
		item  = p;
		do @(posedge clk); while (busy);
		points_sent++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		start = 1'b0;
		while (expected_left != 0 || busy) @(negedge clk);
	endtask

	task automatic write_dims(input logic [DIMS_W-1:0] v);
		wait_idle();
		repeat (SETTLE) @(negedge clk);
		cfg_we   = 1'b1;
		cfg_data = v;
		@(negedge clk);
		cfg_we   = 1'b0;
	endtask

	task automatic run_set(input int n, input int mode);
		int ctr[4];
		for (int k = 0; k < 4; k++) ctr[k] = int'($urandom_range(0, 65535)) - 32768;
		for (int i = 0; i < n; i++) send_point(rand_point(mode, ctr, i == n - 1));
	endtask

	initial begin
		logic [DIMS_W-1:0] dims_plan [8];
		int phase;
		int n;
		dims_plan = '{3'd4, 3'd1, 3'd2, 3'd3, 3'd0, 3'd5, 3'd7, 3'd6};
		arst_n   = 1'b0;
		start    = 1'b0;
		item     = '0;
		cfg_we   = 1'b0;
		cfg_data = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		send_point(mk_point(0, 0, 0, 0, 0, 1'b1));
		send_point(mk_point(-32768, -32768, -32768, -32768, 65535, 1'b0));
		send_point(mk_point(32767, 32767, 32767, 32767, 65535, 1'b0));
		send_point(mk_point(-32768, -32768, -32768, -32767, 65535, 1'b0));
		send_point(mk_point(0, 0, 0, 0, 0, 1'b1));
		// squared distance equal to squared radius must not knock out
		send_point(mk_point(0, 0, 0, 0, 3, 1'b0));
		send_point(mk_point(3, 0, 0, 0, 0, 1'b0));
		send_point(mk_point(2, 2, 0, 0, 5, 1'b0));
		send_point(mk_point(1, 2, 2, 0, 0, 1'b1));
		for (int v = 0; v < 3; v++) begin
			write_dims((v == 0) ? 3'd1 : (v == 1) ? 3'd0 : 3'd7);
			send_point(mk_point(0, 0, 0, 0, 1, 1'b0));
			send_point(mk_point(0, 32767, -32768, 100, 0, 1'b0));
			send_point(mk_point(1, 0, 0, 0, 0, 1'b1));
		end

		phase = 0;
		while (points_sent < 380) begin
			write_dims((phase < 8) ? dims_plan[phase] : DIMS_W'($urandom_range(0, 7)));
			if (phase == 1) run_set(MAX_POINTS, 2);
			if (phase == 3) run_set(MAX_POINTS + 2, 1);
			if (phase == 5) run_set(MAX_POINTS + 1, 0);
			for (int s = 0; s < 5; s++) begin
				n = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 10);
				run_set(n, $urandom_range(0, 2));
				if ($urandom_range(0, 4) == 0) wait_idle();
			end
			phase++;
		end

		wait_idle();
		repeat (20) @(negedge clk);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
sv/edpt_pkg.sv
sv/edpt_store.sv
sv/edpt_dist.sv
sv/edpt_ctrl.sv
sv/epsilon_distinct_point_thinning.sv
dv/edpt_checker.sv
dv/testbench.sv
